// ----- sv/periodic_timer_expiry_queue_defines.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the timer expiry queue
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define PERIODIC_TIMER_EXPIRY_QUEUE_DEFINES_SVH

// property that holds at every clock edge outside reset
`define PTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg
// shared types and codes of the timer expiry queue
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned TagW  = 32;
  localparam int unsigned TimeW = 64;
  localparam int unsigned MaxResults = 16;

  localparam logic [KindW-1:0] KindTick       = 3'd0;
  localparam logic [KindW-1:0] KindCreate     = 3'd1;
  localparam logic [KindW-1:0] KindStart      = 3'd2;
  localparam logic [KindW-1:0] KindStop       = 3'd3;
  localparam logic [KindW-1:0] KindChange     = 3'd4;
  localparam logic [KindW-1:0] KindSetTag     = 3'd5;
  localparam logic [KindW-1:0] KindSetTagRest = 3'd6;
  localparam logic [KindW-1:0] KindDelete     = 3'd7;

  localparam logic ResStatus = 1'b0;
  localparam logic ResExpiry = 1'b1;

  typedef struct packed {
    logic              result_kind;
    logic              status;
    logic [3:0]        expired_id;
    logic [TagW-1:0]   expired_tag;
    logic [TimeW-1:0]  expiry_time;
    logic              last;
  } result_t;

endpackage

// ----- sv/ptq_out_reg.sv -----
// ----------------------------------------------------------------------------
// ptq_out_reg
// one-entry output register for result items
// ----------------------------------------------------------------------------
module ptq_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ptq_pkg::result_t res_i,
  output logic             full_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output ptq_pkg::result_t res_o
);

  logic valid_q;
  ptq_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign full_o    = valid_q && !m_ready_i;
  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// ----- sv/periodic_timer_expiry_queue.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_expiry_queue
// timer table with a sorted list of active timers held in memories
// ----------------------------------------------------------------------------
// one item is in work at a time; the next is accepted while the machine is in
// idle, and a full output register stalls it in place
// a command without list work is decoded and answered by a status item;
// removal scans the list for the timer and shifts the later slots down;
// sorted insertion passes slots with an earlier or equal match time and
// shifts later slots up; a tick emits expired heads, re-inserting periodic ones
// reset clears counters, valid and active flags; memories are not cleared
// ----------------------------------------------------------------------------
`include "periodic_timer_expiry_queue_defines.svh"

module periodic_timer_expiry_queue #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned DELAY_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // kind[2:0], timer_id[6:3], first_delay[38:7], period[70:39], tag[102:71],
  // auto_start[103]
  input  logic [103:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_kind[0], status[1], expired_id[5:2], expired_tag[37:6],
  // expiry_time[101:38]
  output logic [103:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam logic [CW-1:0] NumT = CW'(NUM_TIMERS);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_RMSCAN, S_RMSCAN_W, S_RMSHIFT, S_RMSHIFT_W, S_AFTER_RM,
    S_INS_M, S_INS_SCAN, S_INS_SW, S_INS_CMP, S_INS_SHIFT, S_INS_SHW, S_INS_PUT,
    S_TK_HEAD, S_TK_HW, S_TK_ENT, S_TK_EMIT, S_TK_LAST, S_STATUS
  } state_e;

  typedef enum logic [1:0] { R_NONE, R_START, R_EXPIRE } ret_e;

  // memories
  logic [DELAY_WIDTH-1:0] first_mem [NUM_TIMERS];
  logic [DELAY_WIDTH-1:0] period_mem [NUM_TIMERS];
  logic [31:0]            tag_mem [NUM_TIMERS];
  logic [63:0]            match_mem [NUM_TIMERS];
  logic [IW-1:0]          order_mem [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] valid_q, active_q;
  logic [63:0]  now_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]  maxd_q;
  state_e       state_q;
  ret_e         ret_q;

  // latched input
  logic [2:0]   kind_q;
  logic [3:0]   id_q;
  logic [31:0]  first_in_q, period_in_q, tag_in_q;
  logic         auto_q;

  // working registers
  logic [CW-1:0] pos_q;
  logic [CW-1:0] tgt_q;
  logic [IW-1:0] cur_q;
  logic [63:0]   key_q;
  logic [4:0]    nres_q;
  logic          status_q;
  ptq_pkg::result_t pend_q;

  // memory read ports, registered
  logic [IW-1:0] ord_raddr;
  logic [IW-1:0] ord_rd_q;
  logic [IW-1:0] ent_raddr;
  logic [63:0]   match_rd_q;
  logic [DELAY_WIDTH-1:0] first_rd_q, period_rd_q;
  logic [31:0]   tag_rd_q;

  // memory write ports
  logic          ord_we, match_we, prm_we, tag_we;
  logic [IW-1:0] ord_waddr, ent_waddr;
  logic [IW-1:0] ord_wdata;
  logic [63:0]   match_wdata;

  ptq_pkg::result_t res_d;
  logic             push;
  logic             out_full;
  ptq_pkg::result_t res_out;

  logic [IW-1:0] idx;
  assign idx = IW'(id_q);

  function automatic logic delay_ok(input logic [31:0] v, input logic [31:0] lim);
    logic fits;
    fits = (DELAY_WIDTH >= 32) ? 1'b1 : ((v >> DELAY_WIDTH) == 32'd0);
    return (v <= lim) && fits;
  endfunction

  logic id_in_range, params_ok;
  assign id_in_range = ({28'd0, id_q} < 32'(NUM_TIMERS));
  assign params_ok   = (first_in_q != 32'd0) && delay_ok(first_in_q, maxd_q) &&
                       delay_ok(period_in_q, maxd_q);

  always_ff @(posedge clk_i) begin
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    ord_rd_q <= order_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (match_we) match_mem[ent_waddr] <= match_wdata;
    if (prm_we) begin
      first_mem[ent_waddr]  <= first_in_q[DELAY_WIDTH-1:0];
      period_mem[ent_waddr] <= period_in_q[DELAY_WIDTH-1:0];
    end
    if (tag_we) tag_mem[ent_waddr] <= tag_in_q;
    match_rd_q  <= match_mem[ent_raddr];
    first_rd_q  <= first_mem[ent_raddr];
    period_rd_q <= period_mem[ent_raddr];
    tag_rd_q    <= tag_mem[ent_raddr];
  end

  // memory address and write control
  always_comb begin
    ord_raddr   = pos_q[IW-1:0];
    ent_raddr   = cur_q;
    ord_we      = 1'b0;
    ord_waddr   = pos_q[IW-1:0];
    ord_wdata   = cur_q;
    match_we    = 1'b0;
    prm_we      = 1'b0;
    tag_we      = 1'b0;
    ent_waddr   = cur_q;
    match_wdata = key_q;
    unique case (state_q)
      S_RMSHIFT: ord_raddr = IW'(pos_q + CW'(1));
      S_RMSHIFT_W: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rd_q;
      end
      // entry read follows the list slot just read
      S_INS_SW: ent_raddr = ord_rd_q;
      S_INS_SHIFT: ord_raddr = IW'(pos_q - CW'(1));
      S_INS_SHW: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rd_q;
      end
      S_INS_PUT: begin
        ord_we   = 1'b1;
        match_we = 1'b1;
      end
      S_TK_HEAD: ord_raddr = '0;
      S_DEC: begin
        ent_waddr = idx;
        if (id_in_range && kind_q == ptq_pkg::KindCreate && params_ok) begin
          prm_we = 1'b1;
          tag_we = 1'b1;
        end
        if (id_in_range && kind_q == ptq_pkg::KindChange && params_ok &&
            valid_q[idx] && !active_q[idx]) begin
          prm_we = 1'b1;
        end
        if (id_in_range && kind_q == ptq_pkg::KindSetTag &&
            valid_q[idx] && !active_q[idx]) begin
          tag_we = 1'b1;
        end
      end
      S_AFTER_RM: begin
        if (ret_q != R_EXPIRE && kind_q == ptq_pkg::KindSetTagRest &&
            valid_q[cur_q]) tag_we = 1'b1;
      end
      default: ;
    endcase
  end

  // expiry items wait in pend_q until it is known whether another follows
  always_comb begin
    res_d = pend_q;
    push  = 1'b0;
    unique case (state_q)
      S_TK_EMIT: begin
        if (match_rd_q <= now_q && nres_q != '0 && !out_full) push = 1'b1;
      end
      S_TK_LAST: begin
        if (nres_q != '0 && !out_full) begin
          push       = 1'b1;
          res_d.last = 1'b1;
        end
      end
      S_STATUS: begin
        if (!out_full) begin
          push              = 1'b1;
          res_d             = '0;
          res_d.result_kind = ptq_pkg::ResStatus;
          res_d.status      = status_q;
          res_d.expired_id  = id_q;
          res_d.last        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      maxd_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= R_NONE;
      valid_q   <= '0;
      active_q  <= '0;
      now_q     <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      tgt_q     <= '0;
      cur_q     <= '0;
      key_q     <= '0;
      nres_q    <= '0;
      status_q  <= 1'b0;
      pend_q    <= '0;
      kind_q    <= '0;
      id_q      <= '0;
      first_in_q  <= '0;
      period_in_q <= '0;
      tag_in_q    <= '0;
      auto_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q      <= s_axis_tdata_i[2:0];
            id_q        <= s_axis_tdata_i[6:3];
            first_in_q  <= s_axis_tdata_i[38:7];
            period_in_q <= s_axis_tdata_i[70:39];
            tag_in_q    <= s_axis_tdata_i[102:71];
            auto_q      <= s_axis_tdata_i[103];
            status_q    <= 1'b0;
            nres_q      <= '0;
            state_q     <= S_DEC;
          end
        end
        S_DEC: begin
          cur_q <= idx;
          pos_q <= '0;
          if (kind_q == ptq_pkg::KindTick) begin
            now_q   <= now_q + 64'd1;
            state_q <= S_TK_HEAD;
          end else if (!id_in_range) begin
            status_q <= 1'b1;
            state_q  <= S_STATUS;
          end else begin
            unique case (kind_q)
              ptq_pkg::KindCreate: begin
                if (!params_ok) begin
                  status_q <= 1'b1;
                  state_q  <= S_STATUS;
                end else begin
                  valid_q[idx]  <= 1'b1;
                  active_q[idx] <= 1'b0;
                  state_q       <= active_q[idx] ? S_RMSCAN : S_AFTER_RM;
                end
              end
              ptq_pkg::KindStart: state_q <= S_AFTER_RM;
              ptq_pkg::KindStop, ptq_pkg::KindSetTagRest: begin
                if (valid_q[idx] && active_q[idx]) begin
                  active_q[idx] <= 1'b0;
                  state_q       <= S_RMSCAN;
                end else begin
                  state_q <= S_AFTER_RM;
                end
              end
              ptq_pkg::KindChange: begin
                status_q <= !params_ok;
                state_q  <= S_STATUS;
              end
              ptq_pkg::KindDelete: begin
                if (valid_q[idx] && !active_q[idx]) valid_q[idx] <= 1'b0;
                state_q <= S_STATUS;
              end
              default: state_q <= S_STATUS;
            endcase
          end
        end
        // removal: find cur_q in the list
        S_RMSCAN: begin
          if (pos_q >= cnt_q) begin
            state_q <= S_AFTER_RM;
          end else begin
            state_q <= S_RMSCAN_W;
          end
        end
        S_RMSCAN_W: begin
          if (ord_rd_q == cur_q) begin
            state_q <= S_RMSHIFT;
          end else begin
            pos_q   <= pos_q + CW'(1);
            state_q <= S_RMSCAN;
          end
        end
        S_RMSHIFT: begin
          if (pos_q + CW'(1) >= cnt_q || pos_q + CW'(1) >= NumT) begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_AFTER_RM;
          end else begin
            state_q <= S_RMSHIFT_W;
          end
        end
        S_RMSHIFT_W: begin
          pos_q   <= pos_q + CW'(1);
          state_q <= S_RMSHIFT;
        end
        S_AFTER_RM: begin
          pos_q <= '0;
          if (ret_q == R_EXPIRE) begin
            ret_q <= R_NONE;
            if (period_rd_q != '0) begin
              key_q   <= match_rd_q + 64'(period_rd_q);
              state_q <= S_INS_SCAN;
            end else begin
              active_q[cur_q] <= 1'b0;
              state_q         <= S_TK_HEAD;
            end
          end else if ((kind_q == ptq_pkg::KindCreate && auto_q) ||
                       kind_q == ptq_pkg::KindStart ||
                       kind_q == ptq_pkg::KindSetTagRest) begin
            if (valid_q[cur_q] && !active_q[cur_q]) begin
              state_q <= S_INS_M;
            end else begin
              state_q <= S_STATUS;
            end
          end else begin
            state_q <= S_STATUS;
          end
        end
        // start: first delay of cur_q is on the read port
        S_INS_M: begin
          key_q   <= now_q + 64'(first_rd_q);
          ret_q   <= R_START;
          state_q <= S_INS_SCAN;
        end
        S_INS_SCAN: begin
          if (cnt_q >= NumT) begin
            state_q <= (ret_q == R_START) ? S_STATUS : S_TK_HEAD;
            if (ret_q == R_START) active_q[cur_q] <= 1'b1;
            ret_q   <= R_NONE;
          end else if (pos_q >= cnt_q) begin
            tgt_q   <= cnt_q;
            pos_q   <= cnt_q;
            state_q <= S_INS_SHIFT;
          end else begin
            state_q <= S_INS_SW;
          end
        end
        S_INS_SW: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (match_rd_q <= key_q) begin
            pos_q   <= pos_q + CW'(1);
            state_q <= S_INS_SCAN;
          end else begin
            tgt_q   <= pos_q;
            pos_q   <= cnt_q;
            state_q <= S_INS_SHIFT;
          end
        end
        S_INS_SHIFT: begin
          if (pos_q == tgt_q) begin
            state_q <= S_INS_PUT;
          end else begin
            state_q <= S_INS_SHW;
          end
        end
        S_INS_SHW: begin
          pos_q   <= pos_q - CW'(1);
          state_q <= S_INS_SHIFT;
        end
        S_INS_PUT: begin
          cnt_q           <= cnt_q + CW'(1);
          active_q[cur_q] <= 1'b1;
          state_q         <= (ret_q == R_START) ? S_STATUS : S_TK_HEAD;
          ret_q           <= R_NONE;
        end
        // tick: check head of list
        S_TK_HEAD: begin
          pos_q <= '0;
          if (cnt_q == '0 || nres_q == 5'(ptq_pkg::MaxResults)) begin
            state_q <= S_TK_LAST;
          end else begin
            state_q <= S_TK_HW;
          end
        end
        S_TK_HW: begin
          cur_q   <= ord_rd_q;
          state_q <= S_TK_ENT;
        end
        S_TK_ENT: begin
          state_q <= S_TK_EMIT;
        end
        S_TK_EMIT: begin
          if (match_rd_q > now_q) begin
            state_q <= S_TK_LAST;
          end else if (nres_q == '0 || !out_full) begin
            pend_q             <= '0;
            pend_q.result_kind <= ptq_pkg::ResExpiry;
            pend_q.expired_id  <= 4'(cur_q);
            pend_q.expired_tag <= tag_rd_q;
            pend_q.expiry_time <= match_rd_q;
            nres_q             <= nres_q + 5'd1;
            ret_q              <= R_EXPIRE;
            pos_q              <= '0;
            state_q            <= S_RMSCAN;
          end
        end
        S_TK_LAST: begin
          if (nres_q == '0 || !out_full) state_q <= S_IDLE;
        end
        S_STATUS: begin
          if (!out_full) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ptq_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res_i     (res_d),
    .full_o    (out_full),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res_out)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tdata_o  = {2'b00, res_out.expiry_time, res_out.expired_tag,
                            res_out.expired_id, res_out.status, res_out.result_kind};
  assign m_axis_tlast_o  = res_out.last;

  `PTQ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= NumT, "list count overflow")
  `PTQ_ASSERT_NEXT(a_push_full, clk_i, rst_ni, push, m_axis_tvalid_o, "result lost")
  `PTQ_ASSERT(a_idle_ready, clk_i, rst_ni, (state_q == S_IDLE) || !s_axis_tready_o, "ready")

endmodule

// ----- verif/periodic_timer_expiry_queue_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_expiry_queue_tb
// self-checking bench for the sorted timer table: commands and ticks are
// streamed in, a behavioral timer list predicts status and expiry items,
// and every output item is compared with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_expiry_queue_tb;

  localparam int unsigned NumTimers = 16;
  localparam int unsigned DrainCycles = 1000;
  localparam int unsigned StallLimit = 40000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;

  periodic_timer_expiry_queue DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer table copy
  logic [63:0] now_ticks;
  bit          tmr_valid [NumTimers];
  bit          tmr_active [NumTimers];
  logic [31:0] tmr_first [NumTimers];
  logic [31:0] tmr_period [NumTimers];
  logic [31:0] tmr_tag [NumTimers];
  logic [63:0] tmr_match [NumTimers];
  logic [3:0]  sorted_ids [NumTimers];
  int          sorted_len;
  logic [31:0] delay_limit;

  ptq_pkg::result_t pending_results[$];
  int      error_count = 0;
  int      src_idle_pct = 0;
  int      dst_idle_pct = 0;
  int      quiet_cycles = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic bit delay_fits(logic [31:0] v);
    return v <= delay_limit;
  endfunction

  function automatic void unlink_timer(int id);
    for (int i = 0; i < sorted_len; i++) begin
      if (sorted_ids[i] == id) begin
        for (int j = i; j + 1 < sorted_len; j++) sorted_ids[j] = sorted_ids[j+1];
        sorted_len--;
        return;
      end
    end
  endfunction

  function automatic void link_timer(int id);
    int pos;
    pos = 0;
    if (sorted_len >= NumTimers) return;
    while (pos < sorted_len && tmr_match[sorted_ids[pos]] <= tmr_match[id]) pos++;
    for (int j = sorted_len; j > pos; j--) sorted_ids[j] = sorted_ids[j-1];
    sorted_ids[pos] = id[3:0];
    sorted_len++;
  endfunction

  function automatic void arm_timer(int id);
    if (!tmr_valid[id] || tmr_active[id]) return;
    tmr_match[id] = now_ticks + 64'(tmr_first[id]);
    link_timer(id);
    tmr_active[id] = 1'b1;
  endfunction

  function automatic void disarm_timer(int id);
    if (!tmr_valid[id] || !tmr_active[id]) return;
    unlink_timer(id);
    tmr_active[id] = 1'b0;
  endfunction

  function automatic void predict_results(logic [103:0] d);
    logic [2:0]  kind;
    int          id;
    logic [31:0] first;
    logic [31:0] period;
    logic [31:0] tag;
    bit          auto_go;
    bit          bad;
    int          n;
    int          h;
    logic [63:0] m;
    ptq_pkg::result_t r;
    kind = d[2:0];
    id = int'(d[6:3]);
    first = d[38:7];
    period = d[70:39];
    tag = d[102:71];
    auto_go = d[103];
    bad = 1'b0;
    n = 0;
    if (kind == ptq_pkg::KindTick) begin
      now_ticks++;
      while (sorted_len > 0 && n < ptq_pkg::MaxResults) begin
        h = int'(sorted_ids[0]);
        if (tmr_match[h] > now_ticks) break;
        m = tmr_match[h];
        r = '{ptq_pkg::ResExpiry, 1'b0, h[3:0], tmr_tag[h], m, 1'b0};
        pending_results.push_back(r);
        n++;
        unlink_timer(h);
        if (tmr_period[h] > 0) begin
          tmr_match[h] = m + 64'(tmr_period[h]);
          link_timer(h);
        end else begin
          tmr_active[h] = 1'b0;
        end
      end
      if (n > 0) pending_results[$].last = 1'b1;
      return;
    end
    case (kind)
      ptq_pkg::KindCreate: begin
        if (first == 0 || !delay_fits(first) || !delay_fits(period)) begin
          bad = 1'b1;
        end else begin
          if (tmr_active[id]) unlink_timer(id);
          tmr_first[id] = first;
          tmr_period[id] = period;
          tmr_tag[id] = tag;
          tmr_match[id] = '0;
          tmr_active[id] = 1'b0;
          tmr_valid[id] = 1'b1;
          if (auto_go) arm_timer(id);
        end
      end
      ptq_pkg::KindStart: arm_timer(id);
      ptq_pkg::KindStop: disarm_timer(id);
      ptq_pkg::KindChange: begin
        if (first == 0 || !delay_fits(first) || !delay_fits(period)) begin
          bad = 1'b1;
        end else if (tmr_valid[id] && !tmr_active[id]) begin
          tmr_first[id] = first;
          tmr_period[id] = period;
        end
      end
      ptq_pkg::KindSetTag: if (tmr_valid[id] && !tmr_active[id]) tmr_tag[id] = tag;
      ptq_pkg::KindSetTagRest: begin
        disarm_timer(id);
        if (tmr_valid[id] && !tmr_active[id]) tmr_tag[id] = tag;
        arm_timer(id);
      end
      default: if (tmr_valid[id] && !tmr_active[id]) tmr_valid[id] = 1'b0;
    endcase
    r = '{ptq_pkg::ResStatus, bad, id[3:0], 32'd0, 64'd0, 1'b1};
    pending_results.push_back(r);
  endfunction

  function automatic logic [103:0] pack_item(logic [2:0] kind, logic [3:0] id,
      logic [31:0] first, logic [31:0] period, logic [31:0] tag, bit auto_go);
    return {auto_go, tag, period, first, id, kind};
  endfunction

  task automatic send_item(logic [103:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_results(d);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [2:0] kind, int id, logic [31:0] first,
      logic [31:0] period, logic [31:0] tag, bit auto_go);
    send_item(pack_item(kind, id[3:0], first, period, tag, auto_go));
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    delay_limit = v;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    ptq_pkg::result_t got;
    ptq_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tdata_o[5:2],
              m_axis_tdata_o[37:6], m_axis_tdata_o[101:38], m_axis_tlast_o};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 64'(got.expired_id), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind)
          report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.expired_id !== want.expired_id)
          report_mismatch("expired_id", 64'(got.expired_id), 64'(want.expired_id));
        if (got.expired_tag !== want.expired_tag)
          report_mismatch("expired_tag", 64'(got.expired_tag), 64'(want.expired_tag));
        if (got.expiry_time !== want.expiry_time)
          report_mismatch("expiry_time", got.expiry_time, want.expiry_time);
        if (got.last !== want.last)
          report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(ptq_pkg::KindCreate, 0, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(ptq_pkg::KindCreate, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_cmd(ptq_pkg::KindCreate, 3, 32'd0, 32'd2, 32'h1234, 1'b1);
    send_cmd(ptq_pkg::KindTick, 0, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindTick, 0, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStart, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStop, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStop, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindChange, 15, 32'd2, 32'd3, 0, 1'b0);
    send_cmd(ptq_pkg::KindChange, 15, 32'd0, 32'd3, 0, 1'b0);
    send_cmd(ptq_pkg::KindSetTag, 15, 0, 0, 32'hA5A5_5A5A, 1'b0);
    send_cmd(ptq_pkg::KindStart, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStart, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindChange, 15, 32'd7, 32'd7, 0, 1'b0);
    send_cmd(ptq_pkg::KindSetTag, 15, 0, 0, 32'h1, 1'b0);
    send_cmd(ptq_pkg::KindDelete, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindSetTagRest, 15, 0, 0, 32'h5A5A_A5A5, 1'b0);
    send_cmd(ptq_pkg::KindCreate, 15, 32'd1, 32'd1, 32'h77, 1'b1);
    repeat (3) send_cmd(ptq_pkg::KindTick, 0, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStart, 7, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStop, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindDelete, 15, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindDelete, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_crowded_tick();
    for (int i = 0; i < NumTimers; i++)
      send_cmd(ptq_pkg::KindCreate, i, 32'd1, 32'(i % 2), $urandom(), 1'b1);
    repeat (3) send_cmd(ptq_pkg::KindTick, 0, 0, 0, 0, 1'b0);
    for (int i = 0; i < NumTimers; i++) send_cmd(ptq_pkg::KindStop, i, 0, 0, 0, 1'b0);
  endtask

  task automatic test_delay_limit();
    write_limit(32'd1);
    send_cmd(ptq_pkg::KindCreate, 2, 32'd1, 32'd1, 32'h11, 1'b1);
    send_cmd(ptq_pkg::KindCreate, 4, 32'd2, 32'd0, 32'h22, 1'b0);
    send_cmd(ptq_pkg::KindCreate, 4, 32'd1, 32'd2, 32'h22, 1'b0);
    send_cmd(ptq_pkg::KindChange, 2, 32'd1, 32'd0, 0, 1'b0);
    send_cmd(ptq_pkg::KindTick, 0, 0, 0, 0, 1'b0);
    send_cmd(ptq_pkg::KindStop, 2, 0, 0, 0, 1'b0);
    write_limit(32'd5);
    send_cmd(ptq_pkg::KindChange, 2, 32'd5, 32'd6, 0, 1'b0);
    send_cmd(ptq_pkg::KindChange, 2, 32'd5, 32'd5, 0, 1'b0);
    write_limit(32'hFFFF_FFFF);
  endtask

  task automatic test_random(int count);
    int          pick;
    logic [2:0]  kind;
    logic [31:0] first;
    logic [31:0] period;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = ptq_pkg::KindTick;
      else if (pick < 60) kind = ptq_pkg::KindCreate;
      else kind = 3'($urandom_range(2, 7));
      pick = $urandom_range(99);
      first = (pick < 3) ? 32'd0 : (pick < 88) ? 32'($urandom_range(1, 10)) : $urandom();
      pick = $urandom_range(99);
      period = (pick < 40) ? 32'd0 : (pick < 85) ? 32'($urandom_range(1, 12)) : $urandom();
      send_item(pack_item(kind, 4'($urandom_range(15)), first, period, $urandom(),
                          bit'($urandom_range(1))));
    end
  endtask

  initial begin
    now_ticks = '0;
    sorted_len = 0;
    delay_limit = 32'hFFFF_FFFF;
    foreach (tmr_valid[i]) begin
      tmr_valid[i] = 1'b0;
      tmr_active[i] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_idle_pct = 37;
    dst_idle_pct = 72;
    test_directed();
    test_crowded_tick();
    test_delay_limit();
    test_random(80);
    src_idle_pct = 72;
    dst_idle_pct = 37;
    test_random(80);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random(80);
    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
